// ===== src/tlik_pkg.sv =====
`timescale 1ns / 1ps
package tlik_pkg;

  // field and datapath widths
  localparam int unsigned XW          = 11;
  localparam int unsigned LEN_W       = 10;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned SQ_W        = 21;
  localparam int unsigned D2_W        = 22;
  localparam int unsigned LSQ_W       = 20;
  localparam int unsigned SUM_W       = LEN_W + 1;
  localparam int unsigned N_W         = 23;
  localparam int unsigned MAG_W       = 22;
  localparam int unsigned RAD_W       = 44;
  localparam int unsigned ROOT_W      = RAD_W / 2;
  localparam int unsigned CW          = 34;
  localparam int unsigned ZW          = 26;
  localparam int unsigned INT_FRAC    = 16;
  localparam int unsigned PRESCALE    = 8;
  localparam int unsigned MAX_STAGES  = 24;
  localparam int unsigned ELBOW_W     = 12;
  localparam int unsigned SHOULDER_W  = 14;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 32;

  // parameter defaults
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 4;
  localparam int unsigned CORDIC_STAGES_DEF   = 16;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(200);

  // angles in 2^-16 degree
  localparam logic signed [ZW-1:0] DEG90  = ZW'(90 * (2 ** INT_FRAC));
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180 * (2 ** INT_FRAC));

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_UPPER_ARM = IDX_W'(0),
    REG_FOREARM   = IDX_W'(1)
  } cfg_reg_e;

  // link lengths and terms derived from them
  typedef struct packed {
    logic [LEN_W-1:0] l1;
    logic [LEN_W-1:0] l2;
    logic [LSQ_W-1:0] l1sq;
    logic [LSQ_W-1:0] l2sq;
    logic [RAD_W-1:0] den_e;
  } cfg_t;

  // front end result, one per item
  typedef struct packed {
    logic [RAD_W-1:0]        rad_e;
    logic [RAD_W-1:0]        rad_b;
    logic signed [N_W-1:0]   n_e;
    logic signed [N_W-1:0]   n_b;
    logic                    cl_e;
    logic                    cl_b;
    logic                    unreach;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
  } front_t;

  // flags that ride alongside the cordic pipelines
  typedef struct packed {
    logic unreach;
    logic cl_e;
    logic neg_e;
    logic cl_b;
    logic neg_b;
  } side_t;

  // atan(2^-i) in 2^-16 degree, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:       v = ZW'(2949120);
      1:       v = ZW'(1740967);
      2:       v = ZW'(919879);
      3:       v = ZW'(466945);
      4:       v = ZW'(234379);
      5:       v = ZW'(117304);
      6:       v = ZW'(58666);
      7:       v = ZW'(29335);
      8:       v = ZW'(14668);
      9:       v = ZW'(7334);
      10:      v = ZW'(3667);
      11:      v = ZW'(1833);
      12:      v = ZW'(917);
      13:      v = ZW'(458);
      14:      v = ZW'(229);
      15:      v = ZW'(115);
      16:      v = ZW'(57);
      17:      v = ZW'(29);
      18:      v = ZW'(14);
      19:      v = ZW'(7);
      20:      v = ZW'(4);
      21:      v = ZW'(2);
      22:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/tlik_cfg.sv =====
`timescale 1ns / 1ps
module tlik_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tlik_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [tlik_pkg::LEN_W-1:0]    cfg_data_i,
  output tlik_pkg::cfg_t                cfg_o
);
  import tlik_pkg::*;

  logic [LEN_W-1:0]   l1_q, l1_d, l2_q, l2_d;
  logic [LSQ_W-1:0]   l1sq_q, l2sq_q, l1l2_q;
  logic [RAD_W-1:0]   den_e_q;
  logic [2*LSQ_W-1:0] l1l2_sq;

  assign cfg_ready_o = 1'b1;

  // register write decode
  always_comb begin
    l1_d = l1_q;
    l2_d = l2_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_UPPER_ARM: l1_d = cfg_data_i;
        REG_FOREARM:   l2_d = cfg_data_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LEN_RESET;
      l2_q <= LEN_RESET;
    end else begin
      l1_q <= l1_d;
      l2_q <= l2_d;
    end
  end

  // derived terms, registered from the link lengths; den_e is registered again after l1l2_q
  assign l1l2_sq = (2*LSQ_W)'(l1l2_q) * (2*LSQ_W)'(l1l2_q);

  always_ff @(posedge clk_i) begin
    l1sq_q  <= LSQ_W'(l1_q) * LSQ_W'(l1_q);
    l2sq_q  <= LSQ_W'(l2_q) * LSQ_W'(l2_q);
    l1l2_q  <= LSQ_W'(l1_q) * LSQ_W'(l2_q);
    den_e_q <= RAD_W'({l1l2_sq, 2'b00});
  end

  assign cfg_o.l1    = l1_q;
  assign cfg_o.l2    = l2_q;
  assign cfg_o.l1sq  = l1sq_q;
  assign cfg_o.l2sq  = l2sq_q;
  assign cfg_o.den_e = den_e_q;

endmodule

// ===== src/tlik_front.sv =====
`timescale 1ns / 1ps
module tlik_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [tlik_pkg::XW-1:0]   x_i,
  input  logic signed [tlik_pkg::XW-1:0]   y_i,
  input  tlik_pkg::cfg_t                   cfg_i,
  output logic                             valid_o,
  output tlik_pkg::front_t                 data_o
);
  import tlik_pkg::*;

  logic [4:0] vld_q;

  logic signed [XW-1:0]  x1_q, y1_q, x2_q, y2_q, x3_q, y3_q, x4_q, y4_q;
  logic [SQ_W-1:0]       xx1_q, yy1_q;
  logic [D2_W-1:0]       d2_2_q, d2_3_q;
  logic [SUM_W-1:0]      lsum2_q;
  logic signed [N_W-1:0] ne3_q, nb3_q, ne4_q, nb4_q;
  logic                  un3_q, un4_q;
  logic [RAD_W-1:0]      nsqe4_q, nsqb4_q, denb4_q;
  front_t                f5_q;

  logic signed [2*XW-1:0] xx_s, yy_s;
  logic [2*SUM_W-1:0]     reach;
  logic [MAG_W-1:0]       mag_e, mag_b;
  logic [RAD_W-1:0]       nsq_e, nsq_b, den_b;

  // stage 1: squares of the coordinates
  assign xx_s = (2*XW)'(x_i) * (2*XW)'(x_i);
  assign yy_s = (2*XW)'(y_i) * (2*XW)'(y_i);

  // stage 3: reach and the two cosine numerators
  assign reach = (2*SUM_W)'(lsum2_q) * (2*SUM_W)'(lsum2_q);

  // stage 4: squared numerators and the shoulder denominator
  assign mag_e = ne3_q[N_W-1] ? MAG_W'(-ne3_q) : MAG_W'(ne3_q);
  assign mag_b = nb3_q[N_W-1] ? MAG_W'(-nb3_q) : MAG_W'(nb3_q);
  assign nsq_e = RAD_W'(mag_e) * RAD_W'(mag_e);
  assign nsq_b = RAD_W'(mag_b) * RAD_W'(mag_b);
  assign den_b = RAD_W'({cfg_i.l1sq, 2'b00}) * RAD_W'(d2_3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= x_i;
      y1_q    <= y_i;
      xx1_q   <= xx_s[SQ_W-1:0];
      yy1_q   <= yy_s[SQ_W-1:0];

      // stage 2: distance squared
      x2_q    <= x1_q;
      y2_q    <= y1_q;
      d2_2_q  <= D2_W'(xx1_q) + D2_W'(yy1_q);
      lsum2_q <= SUM_W'(cfg_i.l1) + SUM_W'(cfg_i.l2);

      x3_q    <= x2_q;
      y3_q    <= y2_q;
      d2_3_q  <= d2_2_q;
      un3_q   <= D2_W'(d2_2_q) > D2_W'(reach);
      ne3_q   <= N_W'(cfg_i.l1sq) + N_W'(cfg_i.l2sq) - N_W'(d2_2_q);
      nb3_q   <= N_W'(cfg_i.l1sq) - N_W'(cfg_i.l2sq) + N_W'(d2_2_q);

      x4_q    <= x3_q;
      y4_q    <= y3_q;
      ne4_q   <= ne3_q;
      nb4_q   <= nb3_q;
      un4_q   <= un3_q;
      nsqe4_q <= nsq_e;
      nsqb4_q <= nsq_b;
      denb4_q <= den_b;

      // stage 5: clamp test and radicands
      f5_q.cl_e    <= nsqe4_q >= cfg_i.den_e;
      f5_q.cl_b    <= nsqb4_q >= denb4_q;
      f5_q.rad_e   <= cfg_i.den_e - nsqe4_q;
      f5_q.rad_b   <= denb4_q - nsqb4_q;
      f5_q.n_e     <= ne4_q;
      f5_q.n_b     <= nb4_q;
      f5_q.unreach <= un4_q;
      f5_q.x       <= x4_q;
      f5_q.y       <= y4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign data_o  = f5_q;

endmodule

// ===== src/tlik_isqrt.sv =====
`timescale 1ns / 1ps
module tlik_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [tlik_pkg::RAD_W-1:0]    rad_i,
  output logic [tlik_pkg::ROOT_W-1:0]   root_o
);
  import tlik_pkg::*;

  localparam int unsigned RW = RAD_W + 1;

  logic [RW-1:0] v_q [ROOT_W-1];
  logic [RW-1:0] r_q [ROOT_W];

  // one result bit per stage, restoring square root
  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    localparam int unsigned SH = RAD_W - 2 - 2 * k;
    logic [RW-1:0] v_in, r_in, t, v_d, r_d;

    if (k == 0) begin : g_first
      assign v_in = RW'(rad_i);
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    assign t = r_in + (RW'(1) << SH);

    always_comb begin
      if (v_in >= t) begin
        v_d = v_in - t;
        r_d = (r_in >> 1) + (RW'(1) << SH);
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= r_d;
      end
    end

    if (k < ROOT_W - 1) begin : g_keep
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          v_q[k] <= v_d;
        end
      end
    end
  end

  assign root_o = r_q[ROOT_W-1][ROOT_W-1:0];

endmodule

// ===== src/tlik_cordic.sv =====
`timescale 1ns / 1ps
module tlik_cordic #(
  parameter int unsigned STAGES = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic signed [tlik_pkg::N_W-1:0] x_i,
  input  logic signed [tlik_pkg::N_W-1:0] y_i,
  output logic signed [tlik_pkg::ZW-1:0]  z_o
);
  import tlik_pkg::*;

  logic signed [CW-1:0] xs_q [STAGES];
  logic signed [CW-1:0] ys_q [STAGES];
  logic signed [ZW-1:0] z_q  [STAGES+1];
  logic                 zero_q [STAGES+1];

  logic signed [CW-1:0] xs0, ys0, xp, yp;
  logic signed [ZW-1:0] zp;

  // prescale and rotate into the right half plane
  assign xs0 = {{(CW-N_W){x_i[N_W-1]}}, x_i} <<< PRESCALE;
  assign ys0 = {{(CW-N_W){y_i[N_W-1]}}, y_i} <<< PRESCALE;

  always_comb begin
    xp = xs0;
    yp = ys0;
    zp = '0;
    if (xs0 < 0) begin
      if (ys0 >= 0) begin
        xp = ys0;
        yp = -xs0;
        zp = DEG90;
      end else begin
        xp = -ys0;
        yp = xs0;
        zp = -DEG90;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]   <= xp;
      ys_q[0]   <= yp;
      z_q[0]    <= zp;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // vectoring iterations, one per stage
  for (genvar j = 1; j <= STAGES; j++) begin : g_iter
    localparam int unsigned SH = j - 1;
    logic signed [CW-1:0] nx, ny;
    logic signed [ZW-1:0] nz;

    always_comb begin
      if (ys_q[j-1] >= 0) begin
        nx = xs_q[j-1] + (ys_q[j-1] >>> SH);
        ny = ys_q[j-1] - (xs_q[j-1] >>> SH);
        nz = z_q[j-1] + atan_lut(SH);
      end else begin
        nx = xs_q[j-1] - (ys_q[j-1] >>> SH);
        ny = ys_q[j-1] + (xs_q[j-1] >>> SH);
        nz = z_q[j-1] - atan_lut(SH);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[j]    <= nz;
        zero_q[j] <= zero_q[j-1];
      end
    end

    if (j < STAGES) begin : g_vec
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          xs_q[j] <= nx;
          ys_q[j] <= ny;
        end
      end
    end
  end

  // atan2 of the origin is zero
  assign z_o = zero_q[STAGES] ? '0 : z_q[STAGES];

endmodule

// ===== src/tlik_delay.sv =====
`timescale 1ns / 1ps
module tlik_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [DEPTH-1:0] vld_q;
  logic [W-1:0]     dat_q [DEPTH];

  // valid bits of the shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
      for (int i = 1; i < DEPTH; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // payload taps
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dat_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        dat_q[i] <= dat_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[DEPTH-1];
  assign data_o  = dat_q[DEPTH-1];

endmodule

// ===== src/tlik_post.sv =====
`timescale 1ns / 1ps
module tlik_post #(
  parameter int unsigned ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  tlik_pkg::side_t                     side_i,
  input  logic signed [tlik_pkg::ZW-1:0]      z_e_i,
  input  logic signed [tlik_pkg::ZW-1:0]      z_b_i,
  input  logic signed [tlik_pkg::ZW-1:0]      z_a_i,
  output logic                                valid_o,
  output logic [tlik_pkg::ELBOW_W-1:0]        elbow_o,
  output logic [tlik_pkg::SHOULDER_W-1:0]     shoulder_o,
  output logic                                unreach_o
);
  import tlik_pkg::*;

  localparam int unsigned SH = INT_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned SW = ZW + 1;

  logic [1:0]           vld_q;
  logic signed [ZW-1:0] elbow1_q, beta1_q, alpha1_q;
  logic                 un1_q, un2_q;
  logic [ELBOW_W-1:0]   elbow2_q;
  logic [SHOULDER_W-1:0] shoulder2_q;

  logic signed [ZW-1:0] elbow_z, beta_z, alpha_z;
  logic signed [SW-1:0] sum, sum_r, elbow_r;

  // stage 1: clamp rules for both cosines and for alpha
  always_comb begin
    if (side_i.cl_e) begin
      elbow_z = side_i.neg_e ? DEG180 : '0;
    end else if (z_e_i < 0) begin
      elbow_z = '0;
    end else if (z_e_i > DEG180) begin
      elbow_z = DEG180;
    end else begin
      elbow_z = z_e_i;
    end

    if (side_i.cl_b) begin
      beta_z = side_i.neg_b ? DEG180 : '0;
    end else if (z_b_i < 0) begin
      beta_z = '0;
    end else if (z_b_i > DEG180) begin
      beta_z = DEG180;
    end else begin
      beta_z = z_b_i;
    end

    if (z_a_i > DEG180) begin
      alpha_z = DEG180;
    end else if (z_a_i < -DEG180) begin
      alpha_z = -DEG180;
    end else begin
      alpha_z = z_a_i;
    end
  end

  // stage 2: shoulder sum and rounding to the output unit
  assign sum     = SW'(beta1_q) + SW'(alpha1_q);
  assign sum_r   = (sum + (SW'(1) <<< (SH - 1))) >>> SH;
  assign elbow_r = (SW'(elbow1_q) + (SW'(1) <<< (SH - 1))) >>> SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elbow1_q    <= elbow_z;
      beta1_q     <= beta_z;
      alpha1_q    <= alpha_z;
      un1_q       <= side_i.unreach;
      un2_q       <= un1_q;
      elbow2_q    <= un1_q ? '0 : elbow_r[ELBOW_W-1:0];
      shoulder2_q <= un1_q ? '0 : sum_r[SHOULDER_W-1:0];
    end
  end

  assign valid_o    = vld_q[1];
  assign elbow_o    = elbow2_q;
  assign shoulder_o = shoulder2_q;
  assign unreach_o  = un2_q;

endmodule

// ===== src/two_link_inverse_kinematics.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       s_tdata: x_mm, y_mm
// m_*       out  m_tvalid / m_tready       m_tdata: elbow_angle, shoulder_angle;
//                                          m_tuser: unreachable
// cfg_*     in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one target point per cycle while the output is not stalled; the pipeline has 5
// front stages, 22 square root stages, CORDIC_STAGES (capped at 24) plus one
// cordic stages and 2 rounding stages.
// reset clears the valid bits and loads both link lengths with 200 mm.
// a stalled output freezes the whole pipeline and s_tready drops with it.
// link length writes take effect on items accepted in the same cycle or later.
module two_link_inverse_kinematics #(
  parameter int unsigned ANGLE_FRAC_BITS = tlik_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES   = tlik_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tlik_pkg::IN_TDATA_W-1:0]    s_tdata,   // x_mm, y_mm
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tlik_pkg::OUT_TDATA_W-1:0]   m_tdata,   // elbow_angle, shoulder_angle
  output logic [0:0]                         m_tuser,   // unreachable
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tlik_pkg::IDX_W-1:0]         cfg_index_i,
  input  logic [tlik_pkg::LEN_W-1:0]         cfg_data_i
);
  import tlik_pkg::*;

  localparam int unsigned NSTAGE     = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES
                                                                    : CORDIC_STAGES;
  localparam int unsigned CORDIC_LAT = NSTAGE + 1;

  typedef struct packed {
    logic signed [N_W-1:0] n_e;
    logic signed [N_W-1:0] n_b;
    logic signed [XW-1:0]  x;
    logic signed [XW-1:0]  y;
    logic                  cl_e;
    logic                  cl_b;
    logic                  unreach;
  } mid_t;

  logic                 en;
  cfg_t                 cfg;
  logic                 f_valid, a_valid, b_valid, p_valid;
  front_t               f_data;
  mid_t                 mid_in, mid_out;
  side_t                side_in, side_out;
  logic [ROOT_W-1:0]    root_e, root_b;
  logic signed [ZW-1:0] z_e, z_b, z_a;
  logic [ELBOW_W-1:0]   elbow;
  logic [SHOULDER_W-1:0] shoulder;
  logic                 unreach;

  // whole pipeline moves unless the output holds a result not taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  tlik_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tlik_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_tvalid),
    .x_i     (s_tdata[XW-1:0]),
    .y_i     (s_tdata[2*XW-1:XW]),
    .cfg_i   (cfg),
    .valid_o (f_valid),
    .data_o  (f_data)
  );

  // square roots of both radicands
  tlik_isqrt u_isqrt_e (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (f_data.rad_e),
    .root_o (root_e)
  );

  tlik_isqrt u_isqrt_b (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (f_data.rad_b),
    .root_o (root_b)
  );

  assign mid_in.n_e     = f_data.n_e;
  assign mid_in.n_b     = f_data.n_b;
  assign mid_in.x       = f_data.x;
  assign mid_in.y       = f_data.y;
  assign mid_in.cl_e    = f_data.cl_e;
  assign mid_in.cl_b    = f_data.cl_b;
  assign mid_in.unreach = f_data.unreach;

  tlik_delay #(
    .W     ($bits(mid_t)),
    .DEPTH (ROOT_W)
  ) u_delay_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .data_i  (mid_in),
    .valid_o (a_valid),
    .data_o  (mid_out)
  );

  // three arctangents side by side
  tlik_cordic #(.STAGES(NSTAGE)) u_cordic_e (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (mid_out.n_e),
    .y_i   ($signed(N_W'(root_e))),
    .z_o   (z_e)
  );

  tlik_cordic #(.STAGES(NSTAGE)) u_cordic_b (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (mid_out.n_b),
    .y_i   ($signed(N_W'(root_b))),
    .z_o   (z_b)
  );

  tlik_cordic #(.STAGES(NSTAGE)) u_cordic_a (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed({{(N_W-XW){mid_out.x[XW-1]}}, mid_out.x})),
    .y_i   ($signed({{(N_W-XW){mid_out.y[XW-1]}}, mid_out.y})),
    .z_o   (z_a)
  );

  assign side_in.unreach = mid_out.unreach;
  assign side_in.cl_e    = mid_out.cl_e;
  assign side_in.neg_e   = mid_out.n_e[N_W-1];
  assign side_in.cl_b    = mid_out.cl_b;
  assign side_in.neg_b   = mid_out.n_b[N_W-1];

  tlik_delay #(
    .W     ($bits(side_t)),
    .DEPTH (CORDIC_LAT)
  ) u_delay_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (a_valid),
    .data_i  (side_in),
    .valid_o (b_valid),
    .data_o  (side_out)
  );

  tlik_post #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (b_valid),
    .side_i     (side_out),
    .z_e_i      (z_e),
    .z_b_i      (z_b),
    .z_a_i      (z_a),
    .valid_o    (p_valid),
    .elbow_o    (elbow),
    .shoulder_o (shoulder),
    .unreach_o  (unreach)
  );

  assign m_tvalid = p_valid;
  assign m_tdata  = {{(OUT_TDATA_W-ELBOW_W-SHOULDER_W){1'b0}}, shoulder, elbow};
  assign m_tuser  = unreach;

endmodule

// ===== src/tlik_checker.sv =====
`timescale 1ns / 1ps
module tlik_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [tlik_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [0:0]                         m_tuser
);
  import tlik_pkg::*;

  localparam int unsigned FW = ELBOW_W + SHOULDER_W;

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  // input side follows the output stall
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not track output stall");

  // unreachable points carry zero angles
  a_unreach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser[0] |-> m_tdata[FW-1:0] == '0)
    else $error("unreachable result with nonzero angles");

  // padding bits stay clear
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> m_tdata[OUT_TDATA_W-1:FW] == '0)
    else $error("tdata padding not zero");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import tlik_pkg::*;

  localparam int unsigned FRAC = 4;
  localparam int unsigned STAGES = 16;
  localparam int unsigned LATENCY = STAGES + 30;
  localparam int unsigned RAND_ITEMS = 580;

  // one expected result
  typedef struct {
    logic [ELBOW_W-1:0]    elbow;
    logic [SHOULDER_W-1:0] shoulder;
    logic                  unreach;
  } ik_result_t;

  // arm solver model and store of pending results
  class ik_scoreboard;
    longint l1 = 200;
    longint l2 = 200;
    ik_result_t pending[$];
    int errors = 0;

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint atan_deg(longint y, longint x);
      longint xs, ys, z, t, nx, ny;
      z = 0;
      if (x == 0 && y == 0) return 0;
      xs = x * 256;
      ys = y * 256;
      // pre-rotate into the right half plane
      if (xs < 0) begin
        if (ys >= 0) begin
          t = ys; ys = -xs; xs = t; z = longint'(90) <<< 16;
        end else begin
          t = xs; xs = -ys; ys = t; z = -(longint'(90) <<< 16);
        end
      end
      for (int i = 0; i < STAGES; i++) begin
        if (ys >= 0) begin
          nx = xs + (ys >>> i);
          ny = ys - (xs >>> i);
          z += longint'(atan_lut(i));
        end else begin
          nx = xs - (ys >>> i);
          ny = ys + (xs >>> i);
          z -= longint'(atan_lut(i));
        end
        xs = nx;
        ys = ny;
      end
      return z;
    endfunction

    // angle whose cosine is num / sqrt(den_sq), clamped
    function longint acos_of(longint num, longint unsigned den_sq);
      longint unsigned mag, nsq;
      longint z;
      longint half_turn = longint'(180) <<< 16;
      mag = (num < 0) ? -num : num;
      nsq = mag * mag;
      if (nsq >= den_sq) return (num >= 0) ? 0 : half_turn;
      z = atan_deg(longint'(int_sqrt(den_sq - nsq)), num);
      if (z < 0) z = 0;
      if (z > half_turn) z = half_turn;
      return z;
    endfunction

    function longint to_units(longint z);
      int sh = 16 - FRAC;
      return (z + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function void note_point(logic signed [XW-1:0] xi, logic signed [XW-1:0] yi);
      ik_result_t r;
      longint x, y, d2, reach, elbow, beta, alpha;
      longint half_turn = longint'(180) <<< 16;
      x = xi;
      y = yi;
      d2 = x * x + y * y;
      reach = (l1 + l2) * (l1 + l2);
      if (d2 > reach) begin
        r.elbow = '0;
        r.shoulder = '0;
        r.unreach = 1'b1;
      end else begin
        elbow = acos_of(l1 * l1 + l2 * l2 - d2, 4 * l1 * l1 * l2 * l2);
        beta = acos_of(l1 * l1 + d2 - l2 * l2, 4 * l1 * l1 * d2);
        alpha = atan_deg(y, x);
        if (alpha > half_turn) alpha = half_turn;
        if (alpha < -half_turn) alpha = -half_turn;
        r.elbow = ELBOW_W'(to_units(elbow));
        r.shoulder = SHOULDER_W'(to_units(beta + alpha));
        r.unreach = 1'b0;
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] data, logic user);
      ik_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: tdata %h", data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[ELBOW_W-1:0] !== e.elbow) begin
        $error("elbow_angle: expected %0d, got %0d", e.elbow, data[ELBOW_W-1:0]);
        errors++;
      end
      if (data[ELBOW_W +: SHOULDER_W] !== e.shoulder) begin
        $error("shoulder_angle: expected %0d, got %0d", $signed(e.shoulder),
               $signed(data[ELBOW_W +: SHOULDER_W]));
        errors++;
      end
      if (user !== e.unreach) begin
        $error("unreachable: expected %0b, got %0b", e.unreach, user);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_data = '0;
  bit no_idle = 1'b0;
  int stall_left = 0;
  ik_scoreboard sb = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  two_link_inverse_kinematics dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  // watch input and output transfers
  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready)
      sb.note_point(s_tdata[XW-1:0], s_tdata[XW +: XW]);
    if (rst_n && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser[0]);
  end

  // output back-pressure in short bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && !no_idle && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_point(int x, int y);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, XW'(y), XW'(x)};
    do @(posedge clk); while (!(s_tvalid && s_tready));
  endtask

  task automatic write_length(cfg_reg_e idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= LEN_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    if (idx == REG_UPPER_ARM) sb.l1 = value;
    else sb.l2 = value;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // point biased toward the reachable disc, sometimes anywhere
  task automatic send_random();
    int span, x, y;
    span = sb.l1 + sb.l2 + 2;
    if (span > 1023) span = 1023;
    if ($urandom_range(0, 9) < 7) begin
      x = $urandom_range(0, 2 * span) - span;
      y = $urandom_range(0, 2 * span) - span;
    end else begin
      x = $urandom_range(0, 2047) - 1024;
      y = $urandom_range(0, 2047) - 1024;
    end
    send_point(x, y);
  endtask

  initial begin
    int l1s[9] = '{1, 1023, 1023, 1, 0, 300, 157, 640, 200};
    int l2s[9] = '{1, 1023, 1, 1023, 300, 0, 911, 33, 200};
    int per_phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, axes, reach boundary at reset lengths
    send_point(0, 0);
    send_point(-1024, -1024);
    send_point(1023, 1023);
    send_point(-1024, 1023);
    send_point(1023, -1024);
    send_point(-1024, 0);
    send_point(-1, 0);
    send_point(-5, 0);
    send_point(1023, 0);
    send_point(0, 1023);
    send_point(0, -1024);
    send_point(400, 0);
    send_point(401, 0);
    send_point(0, 400);
    send_point(-400, 0);
    send_point(0, -400);
    send_point(1, 1);
    send_point(100, 100);
    send_point(-100, -100);
    send_point(283, 282);
    send_point(-283, 283);
    send_point(682, 1365 - 1024 * 2 + 1024);
    for (int i = 0; i < 20; i++) send_random();
    drain();

    per_phase = RAND_ITEMS / 9;
    foreach (l1s[p]) begin
      write_length(REG_UPPER_ARM, l1s[p]);
      write_length(REG_FOREARM, l2s[p]);
      if (p == 8) no_idle = 1'b1;
      send_point(0, 0);
      send_point(sb.l1 + sb.l2 > 1023 ? 1023 : sb.l1 + sb.l2, 0);
      send_point(-1, 0);
      for (int i = 0; i < per_phase; i++) send_random();
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
src/tlik_pkg.sv
src/tlik_cfg.sv
src/tlik_front.sv
src/tlik_isqrt.sv
src/tlik_cordic.sv
src/tlik_delay.sv
src/tlik_post.sv
src/two_link_inverse_kinematics.sv
src/tlik_checker.sv
sim/tb_top.sv
